>>> sv/mtq_pkg.sv
// Shared types and constants for the min-tracking queue.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mtq_pkg;

    // Storage size and derived widths
    localparam int QUEUE_CAPACITY = 64;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
    localparam int CNT_W          = $clog2(QUEUE_CAPACITY + 1);
    localparam int COUNT_OUT_W    = 7;
    localparam int STATUS_W       = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Input action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Output beat layout
    localparam int OUT_DATA_W = 80;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_POP_RD,
        S_POP_WR,
        S_MIN
    } t_state;

    // Operand pair for the shared minimum unit
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_min_req;

endpackage

`default_nettype wire

>>> sv/min_tracking_queue.sv
// Top level of the min-tracking queue: sequencer, stack memories and output register.
// Depends on mtq_pkg and the shared minimum unit mtq_smin.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [31:0] value                            | [0] action (0 enq, 1 deq)
//  m_      | out | [31:0] front_value [63:32] current_min  | -
//          |     | [65:64] status [66] queue_empty         |
//          |     | [67] queue_full [74:68] element_count   |
//
// An enqueue steps through the decide and result (min) states; a dequeue adds a pop read and
// a pop write, plus a move read and a move write for each element moved when an empty outbox
// is refilled from the inbox through its one read port and the shared min unit.
// One item is in work at a time; s_tready is high only while the sequencer is idle.
// A stalled result holds the sequencer in its last state until the output register frees.
// Reset (i_rst_n low, synchronous) empties both stacks and drops any pending result.
`default_nettype none

module min_tracking_queue (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [mtq_pkg::DATA_W-1:0]          i_s_tdata,  // [31:0] value
    input  wire  [0:0]                          i_s_tuser,  // [0] action
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [mtq_pkg::OUT_DATA_W-1:0]      o_m_tdata   // front, min, status, empty,
                                                            // full, count, zero pad
);

    mtq_pkg::t_state r_state, n_state;

    logic [mtq_pkg::CNT_W-1:0]   r_in_depth, r_out_depth;
    logic [mtq_pkg::DATA_W-1:0]  r_in_min, r_out_min;
    logic                        r_action;
    logic [mtq_pkg::DATA_W-1:0]  r_value;
    logic [mtq_pkg::DATA_W-1:0]  r_front;
    logic [mtq_pkg::STATUS_W-1:0] r_status;
    logic                        r_m_valid;
    logic [mtq_pkg::OUT_DATA_W-1:0] r_m_data;

    // Stack memories
    logic [mtq_pkg::DATA_W-1:0] m_inbox_val  [mtq_pkg::QUEUE_CAPACITY];
    logic [mtq_pkg::DATA_W-1:0] m_outbox_val [mtq_pkg::QUEUE_CAPACITY];
    logic [mtq_pkg::DATA_W-1:0] m_outbox_min [mtq_pkg::QUEUE_CAPACITY];
    logic [mtq_pkg::DATA_W-1:0] r_in_rd, r_out_rd_val, r_out_rd_min;

    logic [mtq_pkg::CNT_W-1:0]  w_count;
    logic                       w_full, w_empty;
    logic [mtq_pkg::CNT_W-1:0]  w_in_rd_ptr, w_out_rd_ptr, w_out_min_ptr;
    logic [mtq_pkg::CNT_W+mtq_pkg::COUNT_OUT_W-1:0] w_cnt_ext;
    logic [mtq_pkg::DATA_W-1:0] w_cur_min;

    // Sequencer outputs
    logic w_accept, w_in_we, w_out_we, w_res_load;

    // Shared minimum unit
    mtq_pkg::t_min_req           w_req;
    logic [mtq_pkg::DATA_W-1:0]  w_min;

    mtq_smin u_smin (
        .i_req (w_req),
        .o_min (w_min)
    );

    assign w_count       = r_in_depth + r_out_depth;
    assign w_full        = (w_count == mtq_pkg::CNT_W'(mtq_pkg::QUEUE_CAPACITY));
    assign w_empty       = (w_count == '0);
    assign w_in_rd_ptr   = r_in_depth - mtq_pkg::CNT_W'(1);
    assign w_out_rd_ptr  = r_out_depth - mtq_pkg::CNT_W'(1);
    assign w_out_min_ptr = r_out_depth - mtq_pkg::CNT_W'(2);
    assign w_cnt_ext     = {{mtq_pkg::COUNT_OUT_W{1'b0}}, w_count};

    // Route operands to the minimum unit by sequencer step
    always_comb begin
        w_req.a = r_in_min;
        w_req.b = r_out_min;
        unique case (r_state)
            mtq_pkg::S_DECIDE: begin
                w_req.a = r_value;
                w_req.b = r_in_min;
            end
            mtq_pkg::S_MOVE_WR: begin
                w_req.a = r_in_rd;
                w_req.b = r_out_min;
            end
            default: begin
                w_req.a = r_in_min;
                w_req.b = r_out_min;
            end
        endcase
    end

    // Queue minimum after the step, 0 when empty
    always_comb begin
        if (r_in_depth != '0 && r_out_depth != '0) begin
            w_cur_min = w_min;
        end else if (r_in_depth != '0) begin
            w_cur_min = r_in_min;
        end else if (r_out_depth != '0) begin
            w_cur_min = r_out_min;
        end else begin
            w_cur_min = '0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtq_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = mtq_pkg::S_DECIDE;
            end
            mtq_pkg::S_DECIDE: begin
                if (r_action == mtq_pkg::ACT_ENQ || w_empty) begin
                    n_state = mtq_pkg::S_MIN;
                end else if (r_out_depth == '0) begin
                    n_state = mtq_pkg::S_MOVE_RD;
                end else begin
                    n_state = mtq_pkg::S_POP_RD;
                end
            end
            mtq_pkg::S_MOVE_RD: n_state = mtq_pkg::S_MOVE_WR;
            mtq_pkg::S_MOVE_WR: begin
                n_state = (r_in_depth == '0) ? mtq_pkg::S_POP_RD : mtq_pkg::S_MOVE_RD;
            end
            mtq_pkg::S_POP_RD: n_state = mtq_pkg::S_POP_WR;
            mtq_pkg::S_POP_WR: n_state = mtq_pkg::S_MIN;
            mtq_pkg::S_MIN: begin
                if (!r_m_valid || i_m_tready) n_state = mtq_pkg::S_IDLE;
            end
            default: n_state = mtq_pkg::S_IDLE;
        endcase
    end

    // Sequencer controls
    always_comb begin
        o_s_tready = 1'b0;
        w_in_we    = 1'b0;
        w_out_we   = 1'b0;
        w_res_load = 1'b0;
        unique case (r_state)
            mtq_pkg::S_IDLE:    o_s_tready = 1'b1;
            mtq_pkg::S_DECIDE:  w_in_we = (r_action == mtq_pkg::ACT_ENQ) && !w_full;
            mtq_pkg::S_MOVE_WR: w_out_we = 1'b1;
            mtq_pkg::S_MIN:     w_res_load = !r_m_valid || i_m_tready;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign w_accept = o_s_tready && i_s_tvalid;

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtq_pkg::S_IDLE;
            r_in_depth  <= '0;
            r_out_depth <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_we) r_in_depth <= r_in_depth + mtq_pkg::CNT_W'(1);
            if (r_state == mtq_pkg::S_MOVE_RD) r_in_depth <= w_in_rd_ptr;
            if (w_out_we) r_out_depth <= r_out_depth + mtq_pkg::CNT_W'(1);
            if (r_state == mtq_pkg::S_POP_RD) r_out_depth <= w_out_rd_ptr;
        end
    end

    // Item payload, running minima and front value
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_s_tuser[0];
            r_value  <= i_s_tdata;
            r_front  <= '0;
        end
        if (r_state == mtq_pkg::S_DECIDE) begin
            r_status <= mtq_pkg::STATUS_OK;
            if (r_action == mtq_pkg::ACT_ENQ && w_full) r_status <= mtq_pkg::STATUS_FULL;
            if (r_action == mtq_pkg::ACT_DEQ && w_empty) r_status <= mtq_pkg::STATUS_EMPTY;
        end
        if (w_in_we) r_in_min <= (r_in_depth == '0) ? r_value : w_min;
        if (w_out_we) r_out_min <= (r_out_depth == '0) ? r_in_rd : w_min;
        if (r_state == mtq_pkg::S_POP_WR) begin
            r_front   <= r_out_rd_val;
            r_out_min <= r_out_rd_min;
        end
    end

    // Inbox memory: push on enqueue, read top during the move
    always_ff @(posedge i_clk) begin
        if (w_in_we) m_inbox_val[r_in_depth[mtq_pkg::ADDR_W-1:0]] <= r_value;
        r_in_rd <= m_inbox_val[w_in_rd_ptr[mtq_pkg::ADDR_W-1:0]];
    end

    // Outbox memories: fill during the move, read top and the minimum below it on pop
    always_ff @(posedge i_clk) begin
        if (w_out_we) begin
            m_outbox_val[r_out_depth[mtq_pkg::ADDR_W-1:0]] <= r_in_rd;
            m_outbox_min[r_out_depth[mtq_pkg::ADDR_W-1:0]] <=
                (r_out_depth == '0) ? r_in_rd : w_min;
        end
        r_out_rd_val <= m_outbox_val[w_out_rd_ptr[mtq_pkg::ADDR_W-1:0]];
        r_out_rd_min <= m_outbox_min[w_out_min_ptr[mtq_pkg::ADDR_W-1:0]];
    end

    // Output register: load the result, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_m_data <= {5'd0,
                         w_cnt_ext[mtq_pkg::COUNT_OUT_W-1:0],
                         w_full,
                         w_empty,
                         r_status,
                         w_cur_min,
                         r_front};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

>>> sv/mtq_smin.sv
// Shared signed minimum unit of the min-tracking queue.
// Depends on mtq_pkg for the operand struct and data width.
`default_nettype none

module mtq_smin (
    input  wire mtq_pkg::t_min_req        i_req,
    output logic [mtq_pkg::DATA_W-1:0]    o_min
);

    logic w_a_less;

    // Compare as two's complement and pick the smaller
    assign w_a_less = $signed(i_req.a) < $signed(i_req.b);
    assign o_min    = w_a_less ? i_req.a : i_req.b;

endmodule

`default_nettype wire

>>> sv/mtq_checker.sv
// Port-level checks on the min-tracking queue result stream.
// Depends on mtq_pkg for status codes; bound to min_tracking_queue below.
`default_nettype none

module mtq_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_m_tvalid,
    input wire                               i_m_tready,
    input wire [mtq_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled beat holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Rejected enqueue only when full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[65:64] == mtq_pkg::STATUS_FULL |-> o_m_tdata[67])
        else $error("full rejection without full flag");

    // Rejected dequeue only when empty, and an empty queue shows minimum and front zero
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[65:64] == mtq_pkg::STATUS_EMPTY
        |-> o_m_tdata[66] && o_m_tdata[63:32] == 32'd0 && o_m_tdata[31:0] == 32'd0)
        else $error("empty rejection with bad fields");

    // Full and empty never both
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[66] && o_m_tdata[67]))
        else $error("full and empty together");

endmodule

bind min_tracking_queue mtq_checker u_mtq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

>>> tb/min_tracking_queue_tb.sv
// Self-checking testbench for min_tracking_queue: directed table, then phased random traffic.
// A two-stack model of the queue predicts every result beat; depends on mtq_pkg and the RTL.
`timescale 1ns / 100ps

module min_tracking_queue_tb;

    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_PCT     = 36;

    // One result beat, split into its fields
    typedef struct packed {
        logic signed [mtq_pkg::DATA_W-1:0] front_value;
        logic signed [mtq_pkg::DATA_W-1:0] current_min;
        logic [mtq_pkg::STATUS_W-1:0]      status;
        logic                              queue_empty;
        logic                              queue_full;
        logic [mtq_pkg::COUNT_OUT_W-1:0]   element_count;
    } t_queue_result;

    // One directed stimulus row; want is used only when typed is set
    typedef struct {
        logic                              act;
        logic signed [mtq_pkg::DATA_W-1:0] value;
        bit                                typed;
        t_queue_result                     want;
    } t_stim_row;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic [mtq_pkg::DATA_W-1:0]       i_s_tdata  = '0;   // [31:0] value
    logic [0:0]                       i_s_tuser  = '0;   // [0] action
    logic                             i_m_tready = 1'b0;
    logic                             o_s_tready;
    logic                             o_m_tvalid;
    logic [mtq_pkg::OUT_DATA_W-1:0]   o_m_tdata;         // [31:0] front, [63:32] min,
                                                         // [65:64] status, [66] empty,
                                                         // [67] full, [74:68] count

    // Queue model: inbox and outbox stacks with running minima
    logic signed [mtq_pkg::DATA_W-1:0] inbox_vals  [mtq_pkg::QUEUE_CAPACITY];
    logic signed [mtq_pkg::DATA_W-1:0] inbox_mins  [mtq_pkg::QUEUE_CAPACITY];
    logic signed [mtq_pkg::DATA_W-1:0] outbox_vals [mtq_pkg::QUEUE_CAPACITY];
    logic signed [mtq_pkg::DATA_W-1:0] outbox_mins [mtq_pkg::QUEUE_CAPACITY];
    int                                inbox_top  = 0;
    int                                outbox_top = 0;

    t_queue_result pending_results [$];
    t_stim_row     directed_rows [$];
    int            fail_count    = 0;
    int            hold_requests = 0;
    int            hold_served   = 0;
    bit            no_idle       = 1'b0;

    min_tracking_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Generate the 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [mtq_pkg::DATA_W-1:0] smaller(
        logic signed [mtq_pkg::DATA_W-1:0] a,
        logic signed [mtq_pkg::DATA_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Apply one enqueue or dequeue to the model and return the beat it produces
    function automatic t_queue_result predict_queue_step(
        logic act,
        logic signed [mtq_pkg::DATA_W-1:0] value);
        t_queue_result r;
        int            total;
        r     = '0;
        total = inbox_top + outbox_top;
        if (act == mtq_pkg::ACT_ENQ) begin
            if (total >= mtq_pkg::QUEUE_CAPACITY) begin
                r.status = mtq_pkg::STATUS_FULL;
            end else begin
                inbox_vals[inbox_top] = value;
                inbox_mins[inbox_top] = (inbox_top == 0) ? value
                                        : smaller(value, inbox_mins[inbox_top - 1]);
                inbox_top++;
            end
        end else if (total == 0) begin
            r.status = mtq_pkg::STATUS_EMPTY;
        end else begin
            // refill the outbox top first, rebuilding its minima
            if (outbox_top == 0) begin
                while (inbox_top > 0 && outbox_top < mtq_pkg::QUEUE_CAPACITY) begin
                    inbox_top--;
                    outbox_vals[outbox_top] = inbox_vals[inbox_top];
                    outbox_mins[outbox_top] = (outbox_top == 0) ? inbox_vals[inbox_top]
                        : smaller(inbox_vals[inbox_top], outbox_mins[outbox_top - 1]);
                    outbox_top++;
                end
            end
            outbox_top--;
            r.front_value = outbox_vals[outbox_top];
        end

        // minimum of whatever is held in either stack
        if (inbox_top > 0 && outbox_top > 0)
            r.current_min = smaller(inbox_mins[inbox_top - 1], outbox_mins[outbox_top - 1]);
        else if (inbox_top > 0)
            r.current_min = inbox_mins[inbox_top - 1];
        else if (outbox_top > 0)
            r.current_min = outbox_mins[outbox_top - 1];

        total           = inbox_top + outbox_top;
        r.queue_empty   = (total == 0);
        r.queue_full    = (total >= mtq_pkg::QUEUE_CAPACITY);
        r.element_count = mtq_pkg::COUNT_OUT_W'(total);
        return r;
    endfunction

    // Mix of extremes, small values that tie often, and full-range values
    function automatic logic signed [mtq_pkg::DATA_W-1:0] pick_value();
        int small_v;
        small_v = $urandom_range(16);
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return small_v - 8;
            default: return $urandom;
        endcase
    endfunction

    // Offer one beat, wait for it to be taken, then record what should come back
    task automatic send_item(input logic act, input logic signed [mtq_pkg::DATA_W-1:0] value,
                             input bit typed, input t_queue_result want);
        t_queue_result predicted;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_queue_step(act, value);
        pending_results.push_back(typed ? want : predicted);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [mtq_pkg::DATA_W-1:0] want,
                               input logic [mtq_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: random backpressure, with a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served++;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_queue_result got;
        t_queue_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.front_value   = o_m_tdata[31:0];
            got.current_min   = o_m_tdata[63:32];
            got.status        = o_m_tdata[65:64];
            got.queue_empty   = o_m_tdata[66];
            got.queue_full    = o_m_tdata[67];
            got.element_count = o_m_tdata[74:68];
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %0h", o_m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("front_value", want.front_value, got.front_value);
                check_field("current_min", want.current_min, got.current_min);
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("queue_empty", 32'(want.queue_empty), 32'(got.queue_empty));
                check_field("queue_full", 32'(want.queue_full), 32'(got.queue_full));
                check_field("element_count", 32'(want.element_count),
                            32'(got.element_count));
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int phase;
        int phase_len;
        int enq_pct;
        int random_sent;
        logic act;

        // empty at reset, extremes, refill of the outbox, enqueue behind a
        // non-empty outbox, dequeue value ignored, and dequeue when empty
        directed_rows = '{
            '{mtq_pkg::ACT_DEQ, 32'shFFFF_FFFF, 1'b1,
                '{32'sd0, 32'sd0, mtq_pkg::STATUS_EMPTY, 1'b1, 1'b0, 7'd0}},
            '{mtq_pkg::ACT_ENQ, 32'sh7FFF_FFFF, 1'b1,
                '{32'sd0, 32'sh7FFF_FFFF, mtq_pkg::STATUS_OK, 1'b0, 1'b0, 7'd1}},
            '{mtq_pkg::ACT_ENQ, 32'sh8000_0000, 1'b1,
                '{32'sd0, 32'sh8000_0000, mtq_pkg::STATUS_OK, 1'b0, 1'b0, 7'd2}},
            '{mtq_pkg::ACT_ENQ, 32'sd0,         1'b0, '0},
            '{mtq_pkg::ACT_ENQ, -32'sd1,        1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'shFFFF_FFFF, 1'b1,
                '{32'sh7FFF_FFFF, 32'sh8000_0000, mtq_pkg::STATUS_OK, 1'b0, 1'b0, 7'd3}},
            '{mtq_pkg::ACT_ENQ, 32'sd5,         1'b0, '0},
            '{mtq_pkg::ACT_ENQ, 32'sh8000_0001, 1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sh1234_5678, 1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sd0,         1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'shFFFF_FFFF, 1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sd0,         1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sh7FFF_FFFF, 1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sh8000_0000, 1'b1,
                '{32'sd0, 32'sd0, mtq_pkg::STATUS_EMPTY, 1'b1, 1'b0, 7'd0}},
            '{mtq_pkg::ACT_ENQ, 32'sh5555_5555, 1'b0, '0},
            '{mtq_pkg::ACT_ENQ, 32'shAAAA_AAAA, 1'b0, '0},
            '{mtq_pkg::ACT_ENQ, 32'sh5555_5555, 1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sd0,         1'b0, '0},
            '{mtq_pkg::ACT_ENQ, 32'shAAAA_AAAA, 1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sd0,         1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sd0,         1'b0, '0},
            '{mtq_pkg::ACT_DEQ, 32'sd0,         1'b0, '0}
        };

        // hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);

        // random phases: fill past full, drain past empty, balanced, churn
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase % 4)
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                2:       enq_pct = 50;
                default: enq_pct = 60;
            endcase
            no_idle = (phase == 0);
            if (phase == 1)
                hold_requests++;
            phase_len = $urandom_range(40, 120);
            if (phase_len > RANDOM_ITEMS - random_sent)
                phase_len = RANDOM_ITEMS - random_sent;
            repeat (phase_len) begin
                act = ($urandom_range(99) < enq_pct) ? mtq_pkg::ACT_ENQ : mtq_pkg::ACT_DEQ;
                send_item(act, pick_value(), 1'b0, '0);
                random_sent++;
            end
            // let the queue settle before the next phase now and then
            if (phase % 3 == 2) begin
                i_s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            phase++;
        end
        no_idle = 1'b0;

        // drain and look for stray beats
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
